// ===== hdl/dcd8_pkg.sv =====
package dcd8_pkg;

  localparam int VALUE_W    = 27;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 8;

  // values at or above this have more than eight decimal digits
  localparam logic [VALUE_W-1:0] DAMM_LIMIT = VALUE_W'(100000000);

  // v / 10 == (v * RECIP) >> RECIP_SHIFT, exact for any v below 2^32
  localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = RECIP_SHIFT + VALUE_W;

  // check stages, each folds this many digits
  localparam int DAMM_STAGES     = 2;
  localparam int DIGITS_PER_DAMM = NUM_DIGITS / DAMM_STAGES;

  localparam logic [DIGIT_W-1:0] MAX_DIGIT = DIGIT_W'(9);

  // order-10 Damm quasigroup, [interim][digit]
  localparam logic [DIGIT_W-1:0] DAMM_TAB [0:9][0:9] = '{
    '{4'd0, 4'd3, 4'd1, 4'd7, 4'd5, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2},
    '{4'd7, 4'd0, 4'd9, 4'd2, 4'd1, 4'd5, 4'd4, 4'd8, 4'd6, 4'd3},
    '{4'd4, 4'd2, 4'd0, 4'd6, 4'd8, 4'd7, 4'd1, 4'd3, 4'd5, 4'd9},
    '{4'd1, 4'd7, 4'd5, 4'd0, 4'd9, 4'd8, 4'd3, 4'd4, 4'd2, 4'd6},
    '{4'd6, 4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8},
    '{4'd3, 4'd6, 4'd7, 4'd4, 4'd2, 4'd0, 4'd9, 4'd5, 4'd8, 4'd1},
    '{4'd5, 4'd8, 4'd6, 4'd9, 4'd7, 4'd2, 4'd0, 4'd1, 4'd3, 4'd4},
    '{4'd8, 4'd9, 4'd4, 4'd5, 4'd3, 4'd6, 4'd2, 4'd0, 4'd1, 4'd7},
    '{4'd9, 4'd4, 4'd3, 4'd8, 4'd6, 4'd1, 4'd7, 4'd2, 4'd0, 4'd5},
    '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd3, 4'd6, 4'd7, 4'd9, 4'd0}
  };

  // item as it moves down the pipe
  typedef struct packed {
    logic [VALUE_W-1:0]                   value;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits;  // index 0 = least significant
    logic [DIGIT_W-1:0]                   interim;
    logic                                 oor;
  } item_t;

  function automatic logic [DIGIT_W-1:0] damm_next(logic [DIGIT_W-1:0] interim,
                                                    logic [DIGIT_W-1:0] digit);
    logic [DIGIT_W-1:0] res;
    res = '0;
    if (interim <= MAX_DIGIT && digit <= MAX_DIGIT) begin
      res = DAMM_TAB[interim][digit];
    end
    return res;
  endfunction

endpackage

// ===== hdl/dcd8_peel_stage.sv =====
module dcd8_peel_stage #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dcd8_pkg::item_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output dcd8_pkg::item_t  out_item
);
  import dcd8_pkg::*;

  logic               valid_r;
  item_t              item_r;
  item_t              item_nxt;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot10;
  logic [VALUE_W-1:0] rem;

  // divide by ten via reciprocal, remainder is the digit
  always_comb begin
    prod     = PROD_W'(in_item.value) * PROD_W'(RECIP);
    quot     = prod[RECIP_SHIFT +: VALUE_W];
    quot10   = (quot << 3) + (quot << 1);
    rem      = in_item.value - quot10;
    item_nxt = in_item;
    item_nxt.value         = quot;
    item_nxt.digits[STAGE] = rem[DIGIT_W-1:0];
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> item_r.digits[STAGE] <= MAX_DIGIT)
    else $error("peeled digit out of decimal range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(item_r))
    else $error("stalled stage lost or changed its item");

endmodule

// ===== hdl/dcd8_damm_stage.sv =====
module dcd8_damm_stage #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dcd8_pkg::item_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output dcd8_pkg::item_t  out_item
);
  import dcd8_pkg::*;

  localparam int TOP_IDX = NUM_DIGITS - 1 - STAGE * DIGITS_PER_DAMM;

  logic               valid_r;
  item_t              item_r;
  item_t              item_nxt;
  logic [DIGIT_W-1:0] acc;

  // fold this stage's digits, most significant first
  always_comb begin
    acc = in_item.interim;
    for (int k = 0; k < DIGITS_PER_DAMM; k++) begin
      acc = damm_next(acc, in_item.digits[TOP_IDX - k]);
    end
    item_nxt         = in_item;
    item_nxt.interim = acc;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  a_interim_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> item_r.interim <= MAX_DIGIT)
    else $error("damm interim out of decimal range");

endmodule

// ===== hdl/damm_check_digit_8_unit.sv =====
// Registered stages from input accept to out_valid: 8 digit stages, then 2 check stages.
// One item per cycle absent stalls; the slowest stage is a 27x32 reciprocal multiply.
// Stalls back up stage by stage; empty stages keep taking items while out_ready is low.
// Reset (rst_n low, synchronous) clears the stage valid bits only; data regs are not reset.
module damm_check_digit_8_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dcd8_pkg::VALUE_W-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dcd8_pkg::DIGIT_W-1:0]  out_check_digit,
  output logic                          out_out_of_range
);
  import dcd8_pkg::*;

  localparam int NUM_STAGES = NUM_DIGITS + DAMM_STAGES;

  // link i feeds stage i; link NUM_STAGES is the output
  item_t stg_item  [0:NUM_STAGES];
  logic  stg_valid [0:NUM_STAGES];
  logic  stg_ready [0:NUM_STAGES];

  // entry: range flag is decided once, up front
  always_comb begin
    stg_item[0]         = '0;
    stg_item[0].value   = in_value;
    stg_item[0].oor     = (in_value >= DAMM_LIMIT);
  end

  assign stg_valid[0] = in_valid;
  assign in_ready     = stg_ready[0];

  // digit stages: least significant digit peeled first
  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_peel
    dcd8_peel_stage #(
      .STAGE(g)
    ) u_peel (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stg_valid[g]),
      .in_ready (stg_ready[g]),
      .in_item  (stg_item[g]),
      .out_valid(stg_valid[g+1]),
      .out_ready(stg_ready[g+1]),
      .out_item (stg_item[g+1])
    );
  end

  // check stages: Damm chain from the top digit down
  for (genvar g = 0; g < DAMM_STAGES; g++) begin : g_damm
    dcd8_damm_stage #(
      .STAGE(g)
    ) u_damm (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stg_valid[NUM_DIGITS+g]),
      .in_ready (stg_ready[NUM_DIGITS+g]),
      .in_item  (stg_item[NUM_DIGITS+g]),
      .out_valid(stg_valid[NUM_DIGITS+g+1]),
      .out_ready(stg_ready[NUM_DIGITS+g+1]),
      .out_item (stg_item[NUM_DIGITS+g+1])
    );
  end

  // result: out-of-range items report check digit 0
  assign stg_ready[NUM_STAGES] = out_ready;
  assign out_valid             = stg_valid[NUM_STAGES];
  assign out_out_of_range      = stg_item[NUM_STAGES].oor;
  assign out_check_digit       = stg_item[NUM_STAGES].oor ? '0 : stg_item[NUM_STAGES].interim;

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_check_digit == '0)
    else $error("out-of-range item with nonzero check digit");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !stg_valid[NUM_STAGES-1] |-> stg_ready[NUM_STAGES-1])
    else $error("last stages empty but not ready");

endmodule

// ===== verif/damm_check_digit_8_unit_tb.sv =====
module damm_check_digit_8_unit_tb;

  import dcd8_pkg::VALUE_W;
  import dcd8_pkg::DIGIT_W;

  // Values at or above this have a ninth digit and are flagged.
  localparam int unsigned RANGE_END   = 100000000;
  localparam int unsigned VALUE_MAX   = (1 << VALUE_W) - 1;
  // Drain time after the last result: the pipe is 10 deep.
  localparam int          SETTLE_CYC  = 40;
  localparam int          HOLD_CYC    = 80;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          REPORT_MAX  = 10;

  // Order-10 Damm quasigroup, [interim][digit].
  localparam logic [3:0] QUASI [0:9][0:9] = '{
    '{4'd0, 4'd3, 4'd1, 4'd7, 4'd5, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2},
    '{4'd7, 4'd0, 4'd9, 4'd2, 4'd1, 4'd5, 4'd4, 4'd8, 4'd6, 4'd3},
    '{4'd4, 4'd2, 4'd0, 4'd6, 4'd8, 4'd7, 4'd1, 4'd3, 4'd5, 4'd9},
    '{4'd1, 4'd7, 4'd5, 4'd0, 4'd9, 4'd8, 4'd3, 4'd4, 4'd2, 4'd6},
    '{4'd6, 4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8},
    '{4'd3, 4'd6, 4'd7, 4'd4, 4'd2, 4'd0, 4'd9, 4'd5, 4'd8, 4'd1},
    '{4'd5, 4'd8, 4'd6, 4'd9, 4'd7, 4'd2, 4'd0, 4'd1, 4'd3, 4'd4},
    '{4'd8, 4'd9, 4'd4, 4'd5, 4'd3, 4'd6, 4'd2, 4'd0, 4'd1, 4'd7},
    '{4'd9, 4'd4, 4'd3, 4'd8, 4'd6, 4'd1, 4'd7, 4'd2, 4'd0, 4'd5},
    '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd3, 4'd6, 4'd7, 4'd9, 4'd0}
  };

  typedef struct packed {
    logic [DIGIT_W-1:0] check_digit;
    logic               out_of_range;
  } damm_result_t;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value         = '0;
  logic               out_valid;
  logic               out_ready        = 1'b0;
  logic [DIGIT_W-1:0] out_check_digit;
  logic               out_out_of_range;

  // Stimulus side: values waiting to be offered, filled by the sequence below.
  logic [VALUE_W-1:0] values_to_send [$];
  // Check digits owed by the block, oldest first.
  damm_result_t       checks_due [$];

  // Idle burst odds, 1 in idle_odds per item (0 = no idling at all).
  int unsigned idle_odds   = 0;
  // Long receiver hold-offs: requested by the sequence, taken by the receiver.
  int          holds_asked = 0;
  int          holds_taken = 0;

  int          send_gap    = 0;
  int          stall_left  = 0;
  int          hold_left   = 0;
  int          mismatches  = 0;
  int          cycles      = 0;

  damm_result_t want;
  damm_result_t seen;

  damm_check_digit_8_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_check_digit  (out_check_digit),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected check digit: split into eight decimal digits, fold most
  // significant first from interim 0. Oversized values give flag and zero.
  function automatic damm_result_t damm_check_of(logic [VALUE_W-1:0] v);
    damm_result_t r;
    int unsigned  scale;
    logic [3:0]   acc;
    r.check_digit  = '0;
    r.out_of_range = 1'b0;
    if (v >= RANGE_END) begin
      r.out_of_range = 1'b1;
    end else begin
      acc   = '0;
      scale = 10000000;
      for (int k = 0; k < 8; k++) begin
        acc   = QUASI[acc][(v / scale) % 10];
        scale = scale / 10;
      end
      r.check_digit = acc;
    end
    return r;
  endfunction

  // Random value: mostly full eight-digit values, some short ones (leading
  // zeros), some past the top, some right at the range boundary.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned sel;
    int unsigned top;
    sel = $urandom_range(0, 99);
    top = 10;
    if (sel < 70) begin
      return VALUE_W'($urandom_range(0, RANGE_END - 1));
    end else if (sel < 82) begin
      repeat ($urandom_range(0, 6)) top = top * 10;
      return VALUE_W'($urandom_range(0, top - 1));
    end else if (sel < 94) begin
      return VALUE_W'($urandom_range(RANGE_END, VALUE_MAX));
    end else begin
      return VALUE_W'($urandom_range(RANGE_END - 3, RANGE_END + 2));
    end
  endfunction

  task automatic queue_random(int count);
    repeat (count) values_to_send.push_back(pick_value());
  endtask

  // Sender holds back until everything offered is accepted and answered.
  task automatic wait_drained();
    while (values_to_send.size() != 0 || in_valid || checks_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: one nonblocking write per signal per edge. valid stays up with
  // the value held until the item is taken; gaps fall between items.
  always @(posedge clk) begin
    logic               nxt_valid;
    logic [VALUE_W-1:0] nxt_value;
    nxt_valid = in_valid;
    nxt_value = in_value;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      send_gap  = 0;
    end else begin
      if (in_valid && in_ready) begin
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (values_to_send.size() != 0) begin
          nxt_value = values_to_send.pop_front();
          nxt_valid = 1'b1;
          if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            send_gap = $urandom_range(1, 5);
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_value <= nxt_value;
  end

  // Receiver: short random stalls, plus a long hold-off on request so the
  // pipe fills and in_ready drops while the driver keeps offering.
  always @(posedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (!rst_n) begin
      nxt_ready  = 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (holds_taken != holds_asked) begin
      holds_taken++;
      hold_left = HOLD_CYC - 1;
      nxt_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt_ready = 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(0, 4);
      nxt_ready  = 1'b0;
    end
    out_ready <= nxt_ready;
  end

  // Monitor: values seen at the edge are the pre-edge ones, so accepts on
  // both channels are taken here. Push before pop covers any latency.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        checks_due.push_back(damm_check_of(in_value));
      end
      if (out_valid && out_ready) begin
        seen.check_digit  = out_check_digit;
        seen.out_of_range = out_out_of_range;
        if (checks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("unexpected result: check_digit=%0d out_of_range=%0b",
                     seen.check_digit, seen.out_of_range);
          end
        end else begin
          want = checks_due.pop_front();
          if (seen.check_digit !== want.check_digit ||
              seen.out_of_range !== want.out_of_range) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("bad result: check_digit exp %0d got %0d, out_of_range exp %0b got %0b",
                       want.check_digit, seen.check_digit,
                       want.out_of_range, seen.out_of_range);
            end
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("damm_check_digit_8_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, short values, range boundary, known checks.
    idle_odds = 4;
    values_to_send.push_back(VALUE_W'(0));
    values_to_send.push_back(VALUE_W'(VALUE_MAX));       // every bit set
    values_to_send.push_back(VALUE_W'(1));
    values_to_send.push_back(VALUE_W'(9));
    values_to_send.push_back(VALUE_W'(10));
    values_to_send.push_back(VALUE_W'(572));             // check is 4
    values_to_send.push_back(VALUE_W'(5724));            // with its check: 0
    values_to_send.push_back(VALUE_W'(12345678));
    values_to_send.push_back(VALUE_W'(11111111));
    values_to_send.push_back(VALUE_W'(10000000));
    values_to_send.push_back(VALUE_W'(9999999));
    values_to_send.push_back(VALUE_W'(99999998));
    values_to_send.push_back(VALUE_W'(RANGE_END - 1));   // last in range
    values_to_send.push_back(VALUE_W'(RANGE_END));       // first flagged
    values_to_send.push_back(VALUE_W'(RANGE_END + 1));
    values_to_send.push_back(VALUE_W'(1 << (VALUE_W - 1)));
    values_to_send.push_back(VALUE_W'(1 << (VALUE_W - 2)));
    values_to_send.push_back(VALUE_W'(87654321));
    values_to_send.push_back(VALUE_W'(55555555));
    values_to_send.push_back(VALUE_W'(1000));
    wait_drained();

    // Random, moderate idling, with one long receiver hold-off.
    queue_random(500);
    holds_asked++;
    wait_drained();

    // Heavy idling, another hold-off.
    idle_odds = 2;
    queue_random(400);
    holds_asked++;
    wait_drained();

    // Full rate, no idling.
    idle_odds = 0;
    queue_random(400);
    wait_drained();

    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && checks_due.size() == 0) begin
      $display("damm_check_digit_8_unit: match");
    end else begin
      $display("damm_check_digit_8_unit: mismatch");
    end
    $finish;
  end

endmodule
